FILE: rtl/bta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_pkg - shared types and constants of the bitmap tile allocator
// Pool size, map geometry, command and status codes, and the structs that
// pass between the top level and the word tracker.
// ----------------------------------------------------------------------------
package bta_pkg;

  // Pool geometry
  localparam int unsigned TILE_COUNT = 1024;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);
  localparam int unsigned MAP_WORDS  = (TILE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WORD_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned TILE_W     = WORD_AW + BIT_W;

  // Tiles in the last word, and the pad mask of its bits at or above the tile count
  localparam int unsigned LAST_BITS  = TILE_COUNT - (MAP_WORDS - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_PAD =
    (LAST_BITS == WORD_BITS) ? '0 : ~((32'd1 << LAST_BITS) - 32'd1);

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Status codes
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Update of one word's summary after a write back
  typedef struct packed {
    logic               en;
    logic [WORD_AW-1:0] addr;
    logic               full;
  } bta_upd_t;

  // Summary of the map: any word with a free tile, and the lowest such word
  typedef struct packed {
    logic               any_free;
    logic [WORD_AW-1:0] first_word;
  } bta_sum_t;

endpackage

FILE: rtl/bta_map_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_map_ram - simple dual-port synchronous RAM for the used-bit map
// One write and one read a cycle, read data registered.
// ----------------------------------------------------------------------------
module bta_map_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             re_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port, holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/bta_word_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_word_track - per-word valid and full flags of the used-bit map
// Valid marks words written since reset (others read as all free); full marks
// words with no free tile. Gives the lowest word that still has a free tile.
// ----------------------------------------------------------------------------
module bta_word_track import bta_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bta_upd_t           upd_i,
  input  logic [WORD_AW-1:0] query_addr_i,
  output logic               query_vld_o,
  output bta_sum_t           sum_o
);

  logic [MAP_WORDS-1:0] vld_q;
  logic [MAP_WORDS-1:0] full_q;

  // Record the summary of each written word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      full_q <= '0;
    end else if (upd_i.en) begin
      vld_q[upd_i.addr]  <= 1'b1;
      full_q[upd_i.addr] <= upd_i.full;
    end
  end

  // Find the lowest word that is not full
  always_comb begin
    sum_o.any_free   = 1'b0;
    sum_o.first_word = '0;
    for (int i = MAP_WORDS - 1; i >= 0; i--) begin
      if (!full_q[i]) begin
        sum_o.any_free   = 1'b1;
        sum_o.first_word = WORD_AW'(i);
      end
    end
  end

  assign query_vld_o = vld_q[query_addr_i];

endmodule

FILE: rtl/bitmap_tile_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_tile_allocator_top - first-fit tile allocator over a used-bit map
//
//  channel | direction | transfer when              | payload
//  --------+-----------+----------------------------+-------------------------
//  in      | input     | in_valid_i & in_ready_o    | cmd_i, tile_index_i
//  out     | output    | out_valid_o & out_ready_i  | granted_index_o, status_o
//
// The map word of a request is read from the RAM in the transfer cycle, then
// modified and written back from ST_MOD once the output register can take the
// result; a new request is taken only after that single RAM read-modify-write.
// Reset clears the per-word valid and full flags at once; no sweep is needed.
// A result waits in the output register while the next request is taken; the
// write back stalls while that register is still occupied.
// ----------------------------------------------------------------------------
module bitmap_tile_allocator_top import bta_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             cmd_i,
  input  logic [IDX_W-1:0] tile_index_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [IDX_W-1:0] granted_index_o,
  output logic             status_o
);

  typedef enum logic {
    ST_IDLE,
    ST_MOD
  } state_e;

  state_e               state_q;
  logic                 cmd_q;
  logic [WORD_AW-1:0]   waddr_q;
  logic [BIT_W-1:0]     bit_q;
  logic                 skip_q;
  logic                 vld_q;
  logic                 out_valid_q;
  logic [IDX_W-1:0]     granted_q;
  logic                 status_q;

  logic                 in_fire;
  logic                 mod_fire;
  logic                 in_range;
  logic                 skip_d;
  logic [WORD_AW-1:0]   qaddr;
  logic                 qvld;
  bta_sum_t             sum;
  bta_upd_t             upd;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] raw;
  logic [WORD_BITS-1:0] eff;
  logic [WORD_BITS-1:0] pad;
  logic [BIT_W-1:0]     sel_bit;
  logic [WORD_BITS-1:0] sel_mask;
  logic [WORD_BITS-1:0] new_word;
  logic [TILE_W-1:0]    tile;

  // Position of the lowest clear bit of a word
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign mod_fire   = (state_q == ST_MOD) && (!out_valid_q || out_ready_i);

  // Choose the word to read at transfer
  assign in_range = (32'(tile_index_i) < 32'(TILE_COUNT));
  assign qaddr    = (cmd_i == CMD_ALLOC) ? sum.first_word
                                         : WORD_AW'(tile_index_i >> BIT_W);
  assign skip_d   = (cmd_i == CMD_ALLOC) ? !sum.any_free : !in_range;

  bta_word_track u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .upd_i        (upd),
    .query_addr_i (qaddr),
    .query_vld_o  (qvld),
    .sum_o        (sum)
  );

  bta_map_ram #(
    .DEPTH (MAP_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (WORD_AW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (upd.en),
    .wr_addr_i (waddr_q),
    .wr_data_i (new_word),
    .re_i      (in_fire),
    .rd_addr_i (qaddr),
    .rd_data_o (rd_data)
  );

  // Modify the word read back: set the lowest free bit or clear the named one
  always_comb begin
    raw      = vld_q ? rd_data : '0;
    pad      = (32'(waddr_q) == MAP_WORDS - 1) ? LAST_PAD : '0;
    eff      = raw | pad;
    sel_bit  = (cmd_q == CMD_ALLOC) ? lowest_zero(eff) : bit_q;
    sel_mask = WORD_BITS'(1) << sel_bit;
    new_word = (cmd_q == CMD_ALLOC) ? (raw | sel_mask) : (raw & ~sel_mask);
    tile     = {waddr_q, sel_bit};
    upd.en   = mod_fire && !skip_q;
    upd.addr = waddr_q;
    upd.full = ((new_word | pad) == {WORD_BITS{1'b1}});
  end

  // Sequence requests and hold the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cmd_q       <= CMD_ALLOC;
      waddr_q     <= '0;
      bit_q       <= '0;
      skip_q      <= 1'b0;
      vld_q       <= 1'b0;
      granted_q   <= '0;
      status_q    <= STATUS_DONE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            cmd_q   <= cmd_i;
            waddr_q <= qaddr;
            bit_q   <= tile_index_i[BIT_W-1:0];
            skip_q  <= skip_d;
            vld_q   <= qvld;
            state_q <= ST_MOD;
          end
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_MOD: begin
          if (mod_fire) begin
            out_valid_q <= 1'b1;
            granted_q   <= ((cmd_q == CMD_ALLOC) && !skip_q) ? IDX_W'(tile) : '0;
            status_q    <= ((cmd_q == CMD_ALLOC) && skip_q) ? STATUS_FULL
                                                             : STATUS_DONE;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_index_o = granted_q;
  assign status_o        = status_q;

  // An accepted request moves on to the write back
  a_fire_to_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_MOD))
    else $error("accepted request did not reach write back");

  // A grant changes exactly one bit, and that bit was free
  a_grant_one_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mod_fire && (cmd_q == CMD_ALLOC) && !skip_q) |->
      ($onehot(new_word ^ raw) && ((eff & sel_mask) == '0)))
    else $error("grant did not take exactly one free tile");

  // A free request never reports a full pool
  a_free_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mod_fire && (cmd_q == CMD_FREE)) |=> (status_q == STATUS_DONE))
    else $error("free request reported pool full");

  // Write back waits while the result register is occupied
  a_hold_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_MOD) && out_valid_q && !out_ready_i) |=>
      ((state_q == ST_MOD) && $stable(waddr_q)))
    else $error("write back left while result was stalled");

endmodule

FILE: tb/bitmap_tile_allocator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_tile_allocator_top_tb - self-checking bench for the tile allocator
// Drives allocate and free requests through the valid/ready input channel.
// A shadow used-tile map predicts each grant and status, and every result
// transfer is checked against the oldest expected grant. A short directed
// table comes first. Random traffic follows: it fills the pool to full, drains
// it again and mixes the two, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module bitmap_tile_allocator_top_tb;
  import bta_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] granted;
    logic             status;
  } grant_t;

  typedef struct {
    logic             cmd;
    logic [IDX_W-1:0] idx;
    bit               known;
    grant_t           res;
  } dir_row_t;

  localparam int DIR_ROWS   = 16;
  localparam int ITEM_GOAL  = 1850;
  localparam int IDLE_PCT   = 19;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             cmd_i;
  logic [IDX_W-1:0] tile_index_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [IDX_W-1:0] granted_index_o;
  logic             status_o;

  // Shadow of the used-bit map and the grants still in flight
  bit [TILE_COUNT-1:0] shadow_used;
  int                  tiles_in_use;
  int                  peak_in_use;
  grant_t              pending_grants[$];

  int  fail_count;
  int  sent_count;
  int  alloc_count;
  int  free_count;
  int  full_replies;
  bit  quiet;

  // Directed rows: grants typed in where they follow at a glance from an
  // empty pool, the rest left to the shadow map
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{CMD_ALLOC, 10'd0,    1'b1, '{10'd0, STATUS_DONE}},
    '{CMD_ALLOC, 10'd1023, 1'b1, '{10'd1, STATUS_DONE}},
    '{CMD_ALLOC, 10'h2AA,  1'b1, '{10'd2, STATUS_DONE}},
    '{CMD_FREE,  10'd1,    1'b1, '{10'd0, STATUS_DONE}},
    '{CMD_ALLOC, 10'h155,  1'b1, '{10'd1, STATUS_DONE}},
    '{CMD_FREE,  10'd1,    1'b1, '{10'd0, STATUS_DONE}},
    '{CMD_FREE,  10'd1,    1'b1, '{10'd0, STATUS_DONE}},
    '{CMD_FREE,  10'd1023, 1'b1, '{10'd0, STATUS_DONE}},
    '{CMD_FREE,  10'd0,    1'b1, '{10'd0, STATUS_DONE}},
    '{CMD_FREE,  10'h155,  1'b1, '{10'd0, STATUS_DONE}},
    '{CMD_ALLOC, 10'h3FF,  1'b1, '{10'd0, STATUS_DONE}},
    '{CMD_ALLOC, 10'h000,  1'b0, '{10'd0, STATUS_DONE}},
    '{CMD_ALLOC, 10'h2AA,  1'b0, '{10'd0, STATUS_DONE}},
    '{CMD_FREE,  10'd2,    1'b0, '{10'd0, STATUS_DONE}},
    '{CMD_FREE,  10'h200,  1'b0, '{10'd0, STATUS_DONE}},
    '{CMD_ALLOC, 10'h155,  1'b0, '{10'd0, STATUS_DONE}}
  };

  bitmap_tile_allocator_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .tile_index_i    (tile_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .granted_index_o (granted_index_o),
    .status_o        (status_o)
  );

  always #5 clk_i = ~clk_i;

  // Advance the shadow map by one request and return the grant it yields
  function automatic grant_t first_fit_grant(logic cmd, logic [IDX_W-1:0] idx);
    grant_t g;
    g.granted = '0;
    g.status  = STATUS_DONE;
    if (cmd == CMD_ALLOC) begin
      g.status = STATUS_FULL;
      for (int t = 0; t < TILE_COUNT; t++) begin
        if (!shadow_used[t]) begin
          shadow_used[t] = 1'b1;
          tiles_in_use++;
          g.granted = t[IDX_W-1:0];
          g.status  = STATUS_DONE;
          break;
        end
      end
      if (tiles_in_use > peak_in_use) peak_in_use = tiles_in_use;
    end else if (int'(idx) < TILE_COUNT && shadow_used[idx]) begin
      shadow_used[idx] = 1'b0;
      tiles_in_use--;
    end
    return g;
  endfunction

  // Pick a tile that is in use, scanning from a random start
  function automatic logic [IDX_W-1:0] some_used_tile();
    int start;
    start = $urandom_range(TILE_COUNT - 1);
    for (int k = 0; k < TILE_COUNT; k++) begin
      if (shadow_used[(start + k) % TILE_COUNT]) return IDX_W'((start + k) % TILE_COUNT);
    end
    return IDX_W'(start);
  endfunction

  function automatic bit idle_roll();
    return !quiet && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Offer one request from a falling edge, hold it until the transfer, and
  // return at the next falling edge with valid still high
  task automatic offer_request(logic cmd, logic [IDX_W-1:0] idx, bit known, grant_t res);
    grant_t g;
    while (idle_roll()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    tile_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    g = first_fit_grant(cmd, idx);
    pending_grants.push_back(known ? res : g);
    sent_count++;
    if (cmd == CMD_ALLOC) alloc_count++;
    else free_count++;
    @(negedge clk_i);
  endtask

  task automatic random_request(int alloc_pct, int used_pct);
    logic [IDX_W-1:0] idx;
    logic             cmd;
    cmd = ($urandom_range(99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
    idx = IDX_W'($urandom_range(1023));
    if (cmd == CMD_FREE && $urandom_range(99) < used_pct) idx = some_used_tile();
    offer_request(cmd, idx, 1'b0, '0);
  endtask

  // Hold off the sender until every expected grant has come back
  task automatic drain_pending();
    in_valid_i <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk_i);
  endtask

  // Receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= !idle_roll();
  end

  // Check every result transfer against the oldest expected grant
  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_grants.size() == 0) begin
        $error("result transfer with no request pending: granted_index %0d status %0d",
               granted_index_o, status_o);
        fail_count++;
      end else begin
        want = pending_grants.pop_front();
        if (status_o == STATUS_FULL) full_replies++;
        if (granted_index_o !== want.granted) begin
          $error("granted_index: expected %0d, got %0d", want.granted, granted_index_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
      end
    end
  end

  // Guard against a hung handshake
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    cmd_i        = CMD_ALLOC;
    tile_index_i = '0;
    out_ready_i  = 1'b0;
    quiet        = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      offer_request(dir_rows[r].cmd, dir_rows[r].idx, dir_rows[r].known, dir_rows[r].res);
    end
    drain_pending();

    // Mixed traffic, the tail of it without gaps or stalls
    repeat (80) random_request(60, 50);
    quiet = 1'b1;
    repeat (140) random_request(60, 50);
    quiet = 1'b0;

    // Fill the pool, then bounce off full with frees in between
    while (tiles_in_use < TILE_COUNT) random_request(92, 80);
    repeat (40) random_request(65, 90);
    drain_pending();

    // Mostly frees, then an even mix up to the item goal
    repeat (400) random_request(20, 60);
    while (sent_count < ITEM_GOAL) random_request(50, 50);

    drain_pending();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d requests: %0d allocations, %0d frees.",
             sent_count, alloc_count, free_count);
    $display("Saw %0d pool-full replies; peak occupancy %0d of %0d tiles.",
             full_replies, peak_in_use, TILE_COUNT);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/bta_pkg.sv
rtl/bta_map_ram.sv
rtl/bta_word_track.sv
rtl/bitmap_tile_allocator_top.sv
tb/bitmap_tile_allocator_top_tb.sv
